// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the series-sum block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/icrs_pkg.sv
// ---------------------------------------------------------------------------
// icrs_pkg
// Widths, controller states and command/status types of the series-sum block.
// ---------------------------------------------------------------------------
package icrs_pkg;

    localparam int N_W       = 8;   // term count field
    localparam int X_W       = 17;  // argument field
    localparam int OUT_W     = 24;  // result field
    localparam int TERM_W    = 34;  // running term
    localparam int TERM_FRAC = 30;  // fraction bits of term and accumulator
    localparam int ACC_W     = 48;  // running sum

    localparam int MAX_TERMS_DEF = 255;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_X,
        S_MUL_NUM,
        S_DIV,
        S_ACCUM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_x;
        logic mul_num;
        logic div_step;
        logic accum;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic more_terms;
        logic div_last;
        logic out_full;
    } t_dp_status;

endpackage

// File: hw/rtl/icrs_if.sv
// ---------------------------------------------------------------------------
// icrs_if
// Valid/ready channel interfaces for the input and result transactions.
// ---------------------------------------------------------------------------
interface icrs_in_if;
    logic                                valid;
    logic                                ready;
    logic        [icrs_pkg::N_W-1:0]     term_count;
    logic signed [icrs_pkg::X_W-1:0]     x_value;

    modport source (output valid, output term_count, output x_value, input ready);
    modport sink   (input valid, input term_count, input x_value, output ready);
endinterface

interface icrs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [icrs_pkg::OUT_W-1:0]   series_sum;
    logic                                saturated;

    modport source (output valid, output series_sum, output saturated, input ready);
    modport sink   (input valid, input series_sum, input saturated, output ready);
endinterface

// File: hw/rtl/inverse_cube_root_series_sum.sv
// ---------------------------------------------------------------------------
// inverse_cube_root_series_sum
// Sums n terms of the binomial series for 1/cbrt(1+x) in fixed point.
// ---------------------------------------------------------------------------
// Each input transaction carries a term count n and an argument x with
// FRAC_BITS fraction bits. The block starts from a term of exactly one and
// forms every later term as -term*x*(3i-2)/(3i), holding terms and the
// running sum with 30 fraction bits and truncating toward zero after the
// multiply and after the divide. Counts above MAX_TERMS are treated as
// MAX_TERMS, and a count of zero yields zero. The sum is returned with
// FRAC_BITS fraction bits, clipped to the 24-bit range with a flag. One item
// is worked at a time. Each term passes through the loop test, the two
// multiplies, the restoring divider, which retires one quotient bit per
// cycle, and the accumulate. The dividend is PNW bits wide, where PNW is
// (51 - FRAC_BITS) + clog2(MAX_TERMS+1) + 2, i.e. 45 at the defaults. A
// finished result is held in an output register, so the next input
// transaction is taken while the previous result still waits for the
// downstream side.
// ---------------------------------------------------------------------------
module inverse_cube_root_series_sum #(
    parameter int MAX_TERMS = icrs_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = icrs_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    icrs_in_if.sink    i_in,
    icrs_out_if.source o_out
);
    import icrs_pkg::*;

    // Commands flow from the sequencer, status flows back from the datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    icrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath owns the term, the sum, the divider and the result
    // register, and drives the result channel directly.
    icrs_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_term_count (i_in.term_count),
        .i_x_value    (i_in.x_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out        (o_out)
    );

endmodule

// File: hw/rtl/icrs_ctrl.sv
// ---------------------------------------------------------------------------
// icrs_ctrl
// Sequencer that steps the datapath through load, multiply, divide, sum and emit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module icrs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  icrs_pkg::t_dp_status i_status,
    output icrs_pkg::t_dp_cmd    o_cmd
);
    import icrs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.more_terms ? S_MUL_X : S_EMIT;
            end
            S_MUL_X:   n_state = S_MUL_NUM;
            S_MUL_NUM: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM:   n_state = S_CHECK;
            S_EMIT: begin
                if (!i_status.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL_X:   o_cmd.mul_x    = 1'b1;
            S_MUL_NUM: o_cmd.mul_num  = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_ACCUM:   o_cmd.accum    = 1'b1;
            S_EMIT:    o_cmd.emit     = !i_status.out_full;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    `ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "more than one command")
    `ASSERT_NXT(a_div_to_accum, i_clk, i_rst_n, o_cmd.div_step && i_status.div_last, o_cmd.accum, "accumulate must follow the last divide step")
    `ASSERT_NXT(a_accept_check, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK && !o_in_ready, "accepted transaction must start the term loop")

endmodule

// File: hw/rtl/icrs_dp.sv
// ---------------------------------------------------------------------------
// icrs_dp
// Term, accumulator, multipliers, bit-serial divider and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module icrs_dp #(
    parameter int MAX_TERMS = icrs_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = icrs_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [icrs_pkg::N_W-1:0]        i_term_count,
    input  logic signed [icrs_pkg::X_W-1:0] i_x_value,
    input  icrs_pkg::t_dp_cmd    i_cmd,
    output icrs_pkg::t_dp_status o_status,
    icrs_out_if.source           o_out
);
    import icrs_pkg::*;

    localparam int IW   = $clog2(MAX_TERMS + 1);       // term index
    localparam int NW   = IW + 2;                       // 3*i and 3*i-2
    localparam int PRW  = TERM_W + X_W;                 // term * x
    localparam int PW   = PRW - FRAC_BITS;              // rescaled product
    localparam int PNW  = PW + NW;                      // product * numerator
    localparam int CW   = $clog2(PNW);                  // divide step counter
    localparam int QW   = (PNW + 1 > TERM_W) ? PNW + 1 : TERM_W;
    localparam int AW1  = ACC_W + 1;
    localparam int OSH  = TERM_FRAC - FRAC_BITS;

    localparam logic [PRW-1:0] P_RND = PRW'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [AW1-1:0] O_RND = AW1'((64'd1 << OSH) - 64'd1);
    localparam logic signed [TERM_W-1:0] TERM_ONE = TERM_W'(64'd1 << TERM_FRAC);
    localparam logic signed [QW-1:0] Q_TMAX = QW'((64'sd1 <<< (TERM_W - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] Q_TMIN = -Q_TMAX - QW'(1);
    localparam logic signed [AW1-1:0] A_MAX = AW1'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [AW1-1:0] A_MIN = -A_MAX - AW1'(1);
    localparam logic signed [AW1-1:0] O_MAX = AW1'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [AW1-1:0] O_MIN = -O_MAX - AW1'(1);

    logic        [IW-1:0]     r_n;
    logic        [IW-1:0]     r_i;
    logic signed [X_W-1:0]    r_x;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PW-1:0]     r_p;
    logic                     r_neg;
    logic        [PNW-1:0]    r_dvd;
    logic        [NW-1:0]     r_rem;
    logic        [NW-1:0]     r_den;
    logic        [CW-1:0]     r_cnt;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_sum;
    logic                     r_out_sat;

    logic        [IW-1:0]     w_n_clip;
    logic signed [PRW-1:0]    w_prod;
    logic signed [PRW-1:0]    w_prod_b;
    logic signed [PRW-1:0]    w_prod_s;
    logic        [NW-1:0]     w_den;
    logic        [NW-1:0]     w_num;
    logic signed [PNW-1:0]    w_pn;
    logic        [PNW-1:0]    w_pn_mag;
    logic        [NW:0]       w_rsh;
    logic                     w_ge;
    logic signed [QW-1:0]     w_qs;
    logic signed [QW-1:0]     w_nt;
    logic signed [TERM_W-1:0] w_term_c;
    logic signed [AW1-1:0]    w_sum;
    logic signed [ACC_W-1:0]  w_acc_c;
    logic signed [AW1-1:0]    w_ob;
    logic signed [AW1-1:0]    w_os;
    logic signed [OUT_W-1:0]  w_out;
    logic                     w_sat;

    assign w_n_clip = (int'(i_term_count) > MAX_TERMS) ? IW'(MAX_TERMS) : IW'(i_term_count);

    // Product rescaled to the term's scale, truncated toward zero.
    assign w_prod   = PRW'(r_term) * PRW'(r_x);
    assign w_prod_b = w_prod + (w_prod[PRW-1] ? $signed(P_RND) : $signed(PRW'(0)));
    assign w_prod_s = w_prod_b >>> FRAC_BITS;

    assign w_den    = (NW'(r_i) << 1) + NW'(r_i);
    assign w_num    = w_den - NW'(2);
    assign w_pn     = PNW'(r_p) * PNW'($signed({1'b0, w_num}));
    assign w_pn_mag = w_pn[PNW-1] ? PNW'(-w_pn) : PNW'(w_pn);

    // Restoring divide on magnitudes, one quotient bit per cycle.
    assign w_rsh = {r_rem, r_dvd[PNW-1]};
    assign w_ge  = w_rsh >= {1'b0, r_den};

    // The next term is the negated quotient; the sign is reapplied here.
    assign w_qs = QW'({1'b0, r_dvd});
    assign w_nt = r_neg ? w_qs : -w_qs;

    always_comb begin
        if (w_nt > Q_TMAX) begin
            w_term_c = TERM_W'(Q_TMAX);
        end else if (w_nt < Q_TMIN) begin
            w_term_c = TERM_W'(Q_TMIN);
        end else begin
            w_term_c = TERM_W'(w_nt);
        end
    end

    assign w_sum = AW1'(r_acc) + AW1'(w_term_c);

    always_comb begin
        if (w_sum > A_MAX) begin
            w_acc_c = ACC_W'(A_MAX);
        end else if (w_sum < A_MIN) begin
            w_acc_c = ACC_W'(A_MIN);
        end else begin
            w_acc_c = ACC_W'(w_sum);
        end
    end

    // Final rescale toward zero and clip to the result range.
    assign w_ob = AW1'(r_acc) + (r_acc[ACC_W-1] ? $signed(O_RND) : $signed(AW1'(0)));
    assign w_os = w_ob >>> OSH;

    always_comb begin
        w_sat = 1'b1;
        if (w_os > O_MAX) begin
            w_out = OUT_W'(O_MAX);
        end else if (w_os < O_MIN) begin
            w_out = OUT_W'(O_MIN);
        end else begin
            w_out = OUT_W'(w_os);
            w_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_i <= '0;
        end else if (i_cmd.load) begin
            r_n <= w_n_clip;
            r_i <= (w_n_clip == '0) ? IW'(0) : IW'(1);
        end else if (i_cmd.accum) begin
            r_i <= r_i + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x_value;
            if (w_n_clip == '0) begin
                r_term <= '0;
                r_acc  <= '0;
            end else begin
                r_term <= TERM_ONE;
                r_acc  <= ACC_W'(TERM_ONE);
            end
        end else if (i_cmd.accum) begin
            r_term <= w_term_c;
            r_acc  <= w_acc_c;
        end
        if (i_cmd.mul_x) begin
            r_p <= w_prod_s[PW-1:0];
        end
        if (i_cmd.mul_num) begin
            r_neg <= w_pn[PNW-1];
            r_dvd <= w_pn_mag;
            r_rem <= '0;
            r_den <= w_den;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? NW'(w_rsh - {1'b0, r_den}) : NW'(w_rsh);
            r_dvd <= {r_dvd[PNW-2:0], w_ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.emit) begin
            r_out_sum <= w_out;
            r_out_sat <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.more_terms = r_i < r_n;
    assign o_status.div_last   = r_cnt == CW'(PNW - 1);
    assign o_status.out_full   = r_out_valid && !o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.series_sum = r_out_sum;
    assign o_out.saturated  = r_out_sat;

    `ASSERT_IMP(a_emit_room, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || o_out.ready, "result written over a pending transaction")
    `ASSERT_IMP(a_index_bound, i_clk, i_rst_n, 1'b1, r_i <= r_n, "term index ran past the term count")
    `ASSERT_IMP(a_sat_extreme, i_clk, i_rst_n, r_out_valid && r_out_sat, r_out_sum == OUT_W'(O_MAX) || r_out_sum == OUT_W'(O_MIN), "saturated flag without a clipped sum")

endmodule
